>>> rtl/core/thdt_pkg.sv
`timescale 1ns / 1ps

package thdt_pkg;

    localparam int TERM_W  = 16;
    localparam int POS_W   = 8;
    localparam int LAYER_W = 5;
    localparam int ACT_W   = 3;
    localparam int MODE_W  = 2;
    localparam int TAP_W   = 2;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [TERM_W-1:0]  TERM_RESET     = 16'd200;
    localparam logic [TAP_W-1:0]   DOUBLE_TAP     = 2'd2;
    localparam logic [TAP_W-1:0]   TAP_SATURATED  = 2'd3;

    typedef enum logic [1:0] {
        REG_TAPPING_TERM = 2'd0,
        REG_OWN_POSITION = 2'd1,
        REG_TARGET_LAYER = 2'd2
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF       = 2'd0,
        MODE_PENDING   = 2'd1,
        MODE_MOMENTARY = 2'd2,
        MODE_STICKY    = 2'd3
    } mode_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_MO_ON    = 3'd1,
        ACT_MO_OFF   = 3'd2,
        ACT_LOCK_ON  = 3'd3,
        ACT_LOCK_OFF = 3'd4
    } act_t;

    typedef struct packed {
        logic [TERM_W-1:0]  tapping_term;
        logic [POS_W-1:0]   own_position;
        logic [LAYER_W-1:0] target_layer;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [POS_W-1:0]  key_position;
        logic              key_down;
    } item_t;

    typedef struct packed {
        act_t  layer_action;
        logic  tap_word_fire;
        mode_t mode_now;
    } result_t;

endpackage

>>> rtl/core/thdt_if.sv
`timescale 1ns / 1ps

interface thdt_key_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [thdt_pkg::POS_W-1:0]   key_position;
    logic                         key_down;

    modport source (output valid, output mode, output key_position, output key_down,
                    input ready);
    modport sink   (input valid, input mode, input key_position, input key_down,
                    output ready);
endinterface

interface thdt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [thdt_pkg::ACT_W-1:0]   layer_action;
    logic                         tap_word_fire;
    logic [thdt_pkg::MODE_W-1:0]  mode_now;

    modport source (output valid, output layer_action, output tap_word_fire,
                    output mode_now, input ready);
    modport sink   (input valid, input layer_action, input tap_word_fire,
                    input mode_now, output ready);
endinterface

>>> rtl/core/thdt_apb_regs.sv
`timescale 1ns / 1ps

module thdt_apb_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [thdt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [thdt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [thdt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output thdt_pkg::cfg_t                   cfg
);

    logic [thdt_pkg::TERM_W-1:0]  tapping_term_reg;
    logic [thdt_pkg::POS_W-1:0]   own_position_reg;
    logic [thdt_pkg::LAYER_W-1:0] target_layer_reg;
    logic                         wr_en;
    thdt_pkg::reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = thdt_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tapping_term_reg <= thdt_pkg::TERM_RESET;
            own_position_reg <= '0;
            target_layer_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                thdt_pkg::REG_TAPPING_TERM: tapping_term_reg <= pwdata[thdt_pkg::TERM_W-1:0];
                thdt_pkg::REG_OWN_POSITION: own_position_reg <= pwdata[thdt_pkg::POS_W-1:0];
                thdt_pkg::REG_TARGET_LAYER: target_layer_reg <= pwdata[thdt_pkg::LAYER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            thdt_pkg::REG_TAPPING_TERM:
                prdata = {{(thdt_pkg::APB_DATA_W-thdt_pkg::TERM_W){1'b0}}, tapping_term_reg};
            thdt_pkg::REG_OWN_POSITION:
                prdata = {{(thdt_pkg::APB_DATA_W-thdt_pkg::POS_W){1'b0}}, own_position_reg};
            thdt_pkg::REG_TARGET_LAYER:
                prdata = {{(thdt_pkg::APB_DATA_W-thdt_pkg::LAYER_W){1'b0}}, target_layer_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.tapping_term = tapping_term_reg;
    assign cfg.own_position = own_position_reg;
    assign cfg.target_layer = target_layer_reg;

endmodule

>>> rtl/core/thdt_fsm.sv
`timescale 1ns / 1ps

module thdt_fsm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  thdt_pkg::item_t   item,
    input  thdt_pkg::cfg_t    cfg,
    output thdt_pkg::result_t result
);

    thdt_pkg::mode_t              mode_reg, mode_next;
    logic [thdt_pkg::TAP_W-1:0]   tap_count_reg, tap_count_next;
    logic                         held_reg, held_next;
    logic [thdt_pkg::TERM_W-1:0]  countdown_reg, countdown_next;
    logic                         armed_reg, armed_next;
    logic                         sticky_reg, sticky_next;
    thdt_pkg::act_t               act;
    logic                         fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= thdt_pkg::MODE_OFF;
            tap_count_reg <= '0;
            held_reg      <= 1'b0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
            sticky_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            tap_count_reg <= tap_count_next;
            held_reg      <= held_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
            sticky_reg    <= sticky_next;
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        tap_count_next = tap_count_reg;
        held_next      = held_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        sticky_next    = sticky_reg;
        act            = thdt_pkg::ACT_NONE;
        fire           = 1'b0;

        if (item.mode)
        begin
            if (armed_reg)
            begin
                if (countdown_reg[thdt_pkg::TERM_W-1:1] == '0)
                begin
                    // window expired
                    armed_next     = 1'b0;
                    tap_count_next = '0;
                    if (held_reg)
                    begin
                        mode_next = thdt_pkg::MODE_MOMENTARY;
                        act       = thdt_pkg::ACT_MO_ON;
                    end
                    else if (tap_count_reg >= thdt_pkg::DOUBLE_TAP)
                    begin
                        if (sticky_reg)
                        begin
                            act         = thdt_pkg::ACT_LOCK_OFF;
                            mode_next   = thdt_pkg::MODE_OFF;
                            sticky_next = 1'b0;
                        end
                        else
                        begin
                            act         = thdt_pkg::ACT_LOCK_ON;
                            mode_next   = thdt_pkg::MODE_STICKY;
                            sticky_next = 1'b1;
                        end
                    end
                    else if (tap_count_reg != '0)
                    begin
                        fire        = 1'b1;
                        mode_next   = thdt_pkg::MODE_OFF;
                        sticky_next = 1'b0;
                    end
                end
                else
                begin
                    countdown_next = countdown_reg - 16'd1;
                end
            end
        end
        else if (item.key_position == cfg.own_position)
        begin
            if (item.key_down)
            begin
                held_next      = 1'b1;
                tap_count_next = (tap_count_reg == thdt_pkg::TAP_SATURATED) ?
                                 tap_count_reg : tap_count_reg + 2'd1;
                mode_next      = thdt_pkg::MODE_PENDING;
                countdown_next = cfg.tapping_term;
                armed_next     = 1'b1;
            end
            else
            begin
                held_next = 1'b0;
                if (mode_reg == thdt_pkg::MODE_MOMENTARY)
                begin
                    armed_next     = 1'b0;
                    act            = thdt_pkg::ACT_MO_OFF;
                    mode_next      = thdt_pkg::MODE_OFF;
                    tap_count_next = '0;
                end
                else
                begin
                    countdown_next = cfg.tapping_term;
                    armed_next     = 1'b1;
                end
            end
        end
        else if (item.key_down && held_reg && mode_reg != thdt_pkg::MODE_MOMENTARY)
        begin
            // interrupt by another key
            armed_next     = 1'b0;
            tap_count_next = '0;
            mode_next      = thdt_pkg::MODE_MOMENTARY;
            act            = thdt_pkg::ACT_MO_ON;
        end

        result.layer_action  = act;
        result.tap_word_fire = fire;
        result.mode_now      = mode_next;
    end

endmodule

>>> rtl/core/tap_hold_double_tap_layer_fsm.sv
`timescale 1ns / 1ps

// Tap / hold / double-tap classifier for one layer key. Key events and ticks
// enter on key_in, one beat per clock unless stalled; each beat yields exactly one
// command beat, registered first in the input register and then, through the
// next-state logic, in the result register that drives cmd_out.
// A stalled result register holds its beat while the input register still takes
// one more, so the block sustains one beat per cycle whenever cmd_out is ready.
// tapping_term, own_position and target_layer sit on the APB port at byte
// addresses 0x0, 0x4 and 0x8; write them only while no beat is in flight.
module tap_hold_double_tap_layer_fsm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [thdt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [thdt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [thdt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    thdt_key_if.sink                         key_in,
    thdt_cmd_if.source                       cmd_out
);

    thdt_pkg::cfg_t    cfg;
    thdt_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    thdt_pkg::result_t result;
    thdt_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              advance;

    thdt_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thdt_fsm u_fsm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || cmd_out.ready);
    assign key_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_in.valid && key_in.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_in.valid && key_in.ready)
        begin
            in_item_reg.mode         <= key_in.mode;
            in_item_reg.key_position <= key_in.key_position;
            in_item_reg.key_down     <= key_in.key_down;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign cmd_out.valid         = out_valid_reg;
    assign cmd_out.layer_action  = out_reg.layer_action;
    assign cmd_out.tap_word_fire = out_reg.tap_word_fire;
    assign cmd_out.mode_now      = out_reg.mode_now;

endmodule

>>> sim/tb_tap_hold_double_tap_layer_fsm.sv
`timescale 1ns / 1ps

module tb_tap_hold_double_tap_layer_fsm;

    import thdt_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    thdt_key_if key_bus();
    thdt_cmd_if cmd_bus();

    logic        key_valid_q = 1'b0;
    item_t       key_item_q = '0;
    logic        cmd_ready_q = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned gap_max = 9;
    logic        hold_go = 1'b0;
    int unsigned hold_left = 0;
    int unsigned mismatch_count = 0;

    item_t   pending_beats[$];
    result_t expected_cmds[$];

    cfg_t                cfg_now = '{tapping_term: TERM_RESET, own_position: '0,
                                     target_layer: '0};
    mode_t               k_mode = MODE_OFF;
    logic [TAP_W-1:0]    k_taps = '0;
    logic                k_held = 1'b0;
    logic [TERM_W-1:0]   k_count = '0;
    logic                k_armed = 1'b0;
    logic                k_sticky = 1'b0;

    assign key_bus.valid        = key_valid_q;
    assign key_bus.mode         = key_item_q.mode;
    assign key_bus.key_position = key_item_q.key_position;
    assign key_bus.key_down     = key_item_q.key_down;
    assign cmd_bus.ready        = cmd_ready_q;

    tap_hold_double_tap_layer_fsm DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key_in  (key_bus),
        .cmd_out (cmd_bus)
    );

    always #5 clk = ~clk;

    function automatic result_t predict_cmd(input item_t beat);
        result_t r;
        r.layer_action  = ACT_NONE;
        r.tap_word_fire = 1'b0;
        if (beat.mode)
        begin
            if (k_armed)
            begin
                if (k_count <= 16'd1)
                begin
                    k_armed = 1'b0;
                    if (k_held)
                    begin
                        k_taps = '0;
                        k_mode = MODE_MOMENTARY;
                        r.layer_action = ACT_MO_ON;
                    end
                    else
                    begin
                        if (k_taps >= DOUBLE_TAP)
                        begin
                            if (k_sticky)
                            begin
                                r.layer_action = ACT_LOCK_OFF;
                                k_mode = MODE_OFF;
                                k_sticky = 1'b0;
                            end
                            else
                            begin
                                r.layer_action = ACT_LOCK_ON;
                                k_mode = MODE_STICKY;
                                k_sticky = 1'b1;
                            end
                        end
                        else if (k_taps == 2'd1)
                        begin
                            r.tap_word_fire = 1'b1;
                            k_mode = MODE_OFF;
                            k_sticky = 1'b0;
                        end
                        k_taps = '0;
                    end
                end
                else
                begin
                    k_count = k_count - 16'd1;
                end
            end
        end
        else if (beat.key_position == cfg_now.own_position)
        begin
            if (beat.key_down)
            begin
                k_held = 1'b1;
                if (k_taps != TAP_SATURATED)
                    k_taps = k_taps + 2'd1;
                k_mode = MODE_PENDING;
                k_count = cfg_now.tapping_term;
                k_armed = 1'b1;
            end
            else
            begin
                k_held = 1'b0;
                if (k_mode == MODE_MOMENTARY)
                begin
                    k_armed = 1'b0;
                    r.layer_action = ACT_MO_OFF;
                    k_mode = MODE_OFF;
                    k_taps = '0;
                end
                else
                begin
                    k_count = cfg_now.tapping_term;
                    k_armed = 1'b1;
                end
            end
        end
        else if (beat.key_down && k_held && k_mode != MODE_MOMENTARY)
        begin
            k_armed = 1'b0;
            k_taps = '0;
            k_mode = MODE_MOMENTARY;
            r.layer_action = ACT_MO_ON;
        end
        r.mode_now = k_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : key_driver
        item_t nxt;
        if (!rst_n)
        begin
            key_valid_q <= 1'b0;
            tx_wait <= 0;
        end
        else
        begin
            if (key_valid_q && key_bus.ready)
                expected_cmds.push_back(predict_cmd(key_item_q));
            if (!key_valid_q || key_bus.ready)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait <= tx_wait - 1;
                    key_valid_q <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    nxt = pending_beats.pop_front();
                    key_item_q <= nxt;
                    key_valid_q <= 1'b1;
                    tx_wait <= $urandom_range(gap_max, 0);
                end
                else
                begin
                    key_valid_q <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : cmd_monitor
        result_t want;
        int unsigned w;
        if (!rst_n)
        begin
            cmd_ready_q <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            w = rx_wait;
            if (cmd_bus.valid && cmd_ready_q)
            begin
                if (expected_cmds.size() == 0)
                begin
                    report_mismatch("beat with nothing pending", cmd_bus.layer_action, 0);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd_bus.layer_action !== want.layer_action)
                        report_mismatch("layer_action", cmd_bus.layer_action, want.layer_action);
                    if (cmd_bus.tap_word_fire !== want.tap_word_fire)
                        report_mismatch("tap_word_fire", cmd_bus.tap_word_fire,
                                        want.tap_word_fire);
                    if (cmd_bus.mode_now !== want.mode_now)
                        report_mismatch("mode_now", cmd_bus.mode_now, want.mode_now);
                end
                w = $urandom_range(gap_max, 0);
            end
            if (w != 0)
            begin
                rx_wait <= w - 1;
                cmd_ready_q <= 1'b0;
            end
            else
            begin
                rx_wait <= 0;
                cmd_ready_q <= (hold_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin : rx_hold
        if (hold_go)
            hold_left <= 120;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic void push_beat(input logic m, input logic [POS_W-1:0] p,
                                      input logic d);
        item_t b;
        b.mode = m;
        b.key_position = p;
        b.key_down = d;
        pending_beats.push_back(b);
    endfunction

    function automatic void push_ticks(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_beat(1'b1, 8'($urandom), 1'($urandom));
    endfunction

    task automatic add_gesture();
        int unsigned taps;
        int unsigned cap;
        int unsigned k;
        logic [POS_W-1:0] own;
        logic [POS_W-1:0] other;
        own = cfg_now.own_position;
        other = own ^ 8'($urandom_range(255, 1));
        cap = (cfg_now.tapping_term <= 300) ? cfg_now.tapping_term + 1 : 6;
        if ($urandom_range(9, 0) < 7)
        begin
            taps = $urandom_range(4, 1);
            for (k = 0; k < taps; k++)
            begin
                push_beat(1'b0, own, 1'b1);
                if ($urandom_range(9, 0) < 3)
                    push_ticks($urandom_range(cap, 0));
                if ($urandom_range(9, 0) < 2)
                begin
                    push_beat(1'b0, other, 1'b1);
                    push_beat(1'b0, other, 1'b0);
                end
                push_beat(1'b0, own, 1'b0);
                if (k + 1 < taps)
                    push_ticks($urandom_range((cap > 2) ? cap - 2 : 0, 0));
            end
            push_ticks(($urandom_range(3, 0) != 0) ? cap : $urandom_range(cap, 0));
        end
        else
        begin
            for (k = $urandom_range(4, 1); k != 0; k--)
                push_beat(1'($urandom), ($urandom_range(1, 0) != 0) ? own : 8'($urandom),
                          1'($urandom));
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_beats.size() != 0 || key_valid_q || expected_cmds.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << 2;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input reg_idx_t idx, input logic [APB_DATA_W-1:0] mask,
                            input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        logic rdy;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_ADDR_W'(idx) << 2;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            got = prdata;
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (want & mask))
            report_mismatch($sformatf("readback of %s", idx.name()), got & mask, want & mask);
    endtask

    task automatic set_config(input int unsigned term, input int unsigned pos,
                              input int unsigned layer);
        apb_write(REG_TAPPING_TERM, term);
        apb_write(REG_OWN_POSITION, pos);
        apb_write(REG_TARGET_LAYER, layer);
        cfg_now.tapping_term = 16'(term);
        cfg_now.own_position = 8'(pos);
        cfg_now.target_layer = 5'(layer);
        apb_read(REG_TAPPING_TERM, 32'h0000_FFFF, term);
        apb_read(REG_OWN_POSITION, 32'h0000_00FF, pos);
        apb_read(REG_TARGET_LAYER, 32'h0000_001F, layer);
    endtask

    task automatic run_phase(input int unsigned term, input int unsigned pos,
                             input int unsigned layer, input int unsigned beats,
                             input int unsigned gaps, input bit squeeze);
        set_config(term, pos, layer);
        gap_max <= gaps;
        while (pending_beats.size() < beats)
            add_gesture();
        if (squeeze)
        begin
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        push_beat(1'b1, 8'hFF, 1'b1);
        push_beat(1'b0, 8'h00, 1'b0);
        push_beat(1'b0, 8'hFF, 1'b0);
        push_beat(1'b0, 8'h00, 1'b1);
        push_beat(1'b0, 8'hFF, 1'b1);
        push_beat(1'b0, 8'h00, 1'b0);
        wait_idle();

        set_config(1, 255, 31);
        repeat (4)
        begin
            push_beat(1'b0, 8'hFF, 1'b1);
            push_beat(1'b0, 8'hFF, 1'b0);
        end
        push_beat(1'b1, 8'h00, 1'b0);
        repeat (2)
        begin
            push_beat(1'b0, 8'hFF, 1'b1);
            push_beat(1'b0, 8'hFF, 1'b0);
        end
        push_beat(1'b1, 8'h00, 1'b0);
        push_beat(1'b0, 8'hFF, 1'b1);
        push_beat(1'b0, 8'hFF, 1'b0);
        push_beat(1'b1, 8'h00, 1'b1);
        push_beat(1'b0, 8'hFF, 1'b1);
        push_beat(1'b1, 8'h5A, 1'b0);
        push_beat(1'b0, 8'hFF, 1'b0);
        wait_idle();

        run_phase(1, $urandom_range(255, 0), 0, 250, 9, 1'b0);
        run_phase(3, 8'hA5, $urandom_range(31, 0), 250, 0, 1'b1);
        run_phase($urandom_range(40, 4), $urandom_range(255, 0), $urandom_range(31, 0),
                  300, 9, 1'b0);
        run_phase(200, 0, 10, 300, 9, 1'b0);
        run_phase(65535, 255, 31, 100, 9, 1'b0);

        if (mismatch_count == 0)
            $display("tb_tap_hold_double_tap_layer_fsm: clean");
        else
            $display("tb_tap_hold_double_tap_layer_fsm: errors");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb_tap_hold_double_tap_layer_fsm: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/thdt_pkg.sv
rtl/core/thdt_if.sv
rtl/core/thdt_apb_regs.sv
rtl/core/thdt_fsm.sv
rtl/core/tap_hold_double_tap_layer_fsm.sv
sim/tb_tap_hold_double_tap_layer_fsm.sv
